// File: rtl/advbox_pkg.sv
`timescale 1ns / 1ps

package advbox_pkg;

    // grid and number format
    localparam int MAX_ROW_LENGTH = 2048;
    localparam int FRAC_BITS      = 16;
    localparam int DATA_W         = 32;
    localparam int ROW_LEN_W      = 12;
    localparam int ROW_W          = 16;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = (COL_W + 1 > ROW_LEN_W) ? COL_W + 1 : ROW_LEN_W;

    // datapath widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int PSA_W  = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - FRAC_BITS;
    localparam int RES_W  = SH_W + 1;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration port
    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH     = 4'd0,
        REG_ROW_COUNT      = 4'd1,
        REG_SOURCE_GAIN    = 4'd2,
        REG_NEIGHBOUR_GAIN = 4'd3
    } t_cfg_reg;

    // item after the line buffer read is issued
    typedef struct packed {
        logic signed [DATA_W-1:0] src;
        logic signed [DATA_W-1:0] bnd;
        logic [COL_W-1:0]         col;
        logic                     is_bnd;
        logic                     rend;
        logic                     gend;
    } t_s1;

    // item with the source and above products combined
    typedef struct packed {
        logic signed [PSA_W-1:0]  p_sa;
        logic signed [DATA_W-1:0] above;
        logic signed [DATA_W-1:0] bnd;
        logic [COL_W-1:0]         col;
        logic                     is_bnd;
        logic                     rend;
        logic                     gend;
    } t_s2;

    // finished result item
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     rend;
        logic                     gend;
    } t_out;

endpackage

// File: rtl/advection_box_scheme_stencil.sv
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// input    | in        | i_in_valid/o_in_ready  | i_source_value, i_boundary_value
// result   | out       | o_out_valid/i_out_ready| o_solution_value, o_row_end, o_grid_end
// config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; an item passes stage 1, the loop stage and the output register.
// The rate is set by the loop on the left neighbour: one multiply, add and saturate per cycle.
// The line buffer is one memory, read at accept and written back as the item leaves the loop stage.
// The line buffer is not cleared by reset; row 0 never uses what it reads.
// When the result is not taken, up to three items are held and input ready drops.

module advection_box_scheme_stencil
    import advbox_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [DATA_W-1:0]    i_source_value,
    input  logic signed [DATA_W-1:0]    i_boundary_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_W-1:0]    o_solution_value,
    output logic                        o_row_end,
    output logic                        o_grid_end,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data
);

    // configuration registers
    logic [ROW_LEN_W-1:0]       r_row_length;
    logic [ROW_W-1:0]           r_row_count;
    logic signed [DATA_W-1:0]   r_source_gain;
    logic signed [DATA_W-1:0]   r_neighbour_gain;

    // counters and loop state
    logic [COL_W-1:0]           r_col;
    logic [ROW_W-1:0]           r_row;
    logic signed [DATA_W-1:0]   r_left;
    logic signed [DATA_W-1:0]   r_diag;

    // pipeline registers
    logic                       r_s1_valid;
    t_s1                        r_s1;
    logic                       r_s1_fwd;
    logic signed [DATA_W-1:0]   r_s1_fwd_data;
    logic                       r_s2_valid;
    t_s2                        r_s2;
    logic                       r_out_valid;
    t_out                       r_out;

    // line buffer
    logic signed [DATA_W-1:0]   mem [0:MAX_ROW_LENGTH-1];
    logic signed [DATA_W-1:0]   r_rd_data;

    // flow control
    logic out_free, s2_go, s2_free, s1_go, s1_free, in_acc;

    assign out_free = !r_out_valid || i_out_ready;
    assign s2_go    = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || s2_go;
    assign s1_go    = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s1_go;
    assign in_acc   = i_in_valid && s1_free;

    assign o_in_ready  = s1_free;
    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length     <= ROW_LEN_W'(2048);
            r_row_count      <= ROW_W'(2000);
            r_source_gain    <= DATA_W'(32768);
            r_neighbour_gain <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW_LENGTH:     r_row_length     <= i_cfg_data[ROW_LEN_W-1:0];
                REG_ROW_COUNT:      r_row_count      <= i_cfg_data[ROW_W-1:0];
                REG_SOURCE_GAIN:    r_source_gain    <= $signed(i_cfg_data);
                REG_NEIGHBOUR_GAIN: r_neighbour_gain <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // position of the incoming item
    logic [LEN_W-1:0]   len_raw, len;
    logic [COL_W-1:0]   s0_col;
    logic [ROW_W-1:0]   rows;
    logic               s0_rend, s0_gend, s0_bnd;

    always_comb begin
        len_raw = LEN_W'(r_row_length);
        if (len_raw < LEN_W'(2))
            len = LEN_W'(2);
        else if (len_raw > LEN_W'(MAX_ROW_LENGTH))
            len = LEN_W'(MAX_ROW_LENGTH);
        else
            len = len_raw;
        s0_col  = (LEN_W'(r_col) >= len) ? COL_W'(len - LEN_W'(1)) : r_col;
        rows    = (r_row_count == '0) ? ROW_W'(1) : r_row_count;
        s0_rend = (LEN_W'(s0_col) + LEN_W'(1)) >= len;
        s0_gend = s0_rend && (({1'b0, r_row} + (ROW_W + 1)'(1)) >= {1'b0, rows});
        s0_bnd  = (r_row == '0) || (s0_col == '0);
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (s0_rend) begin
                r_col <= '0;
                r_row <= s0_gend ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= s0_col + COL_W'(1);
            end
        end
    end

    // loop stage: new value from left, above, diagonal and source
    logic signed [PROD_W-1:0]   p_left;
    logic signed [SUM_W-1:0]    total;
    logic signed [SH_W-1:0]     shifted;
    logic signed [RES_W-1:0]    res;
    logic [RES_W-DATA_W:0]      res_hi;
    logic signed [DATA_W-1:0]   sat_val, s2_value;

    always_comb begin
        p_left  = r_neighbour_gain * r_left;
        total   = SUM_W'(r_s2.p_sa) - SUM_W'(p_left);
        shifted = SH_W'(total >>> FRAC_BITS);
        res     = RES_W'(shifted) + RES_W'(r_diag);
        res_hi  = res[RES_W-1:DATA_W-1];
        if ((&res_hi) || !(|res_hi))
            sat_val = res[DATA_W-1:0];
        else
            sat_val = res[RES_W-1] ? DATA_MIN : DATA_MAX;
        s2_value = r_s2.is_bnd ? r_s2.bnd : sat_val;
    end

    // line buffer read at accept, write back from the loop stage
    always_ff @(posedge i_clk) begin
        if (s2_go)
            mem[r_s2.col] <= s2_value;
        if (in_acc)
            r_rd_data <= mem[s0_col];
    end

    // stage 1 load, with bypass of a same-cycle write to the column read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1.src      <= i_source_value;
            r_s1.bnd      <= i_boundary_value;
            r_s1.col      <= s0_col;
            r_s1.is_bnd   <= s0_bnd;
            r_s1.rend     <= s0_rend;
            r_s1.gend     <= s0_gend;
            r_s1_fwd      <= s2_go && (r_s2.col == s0_col);
            r_s1_fwd_data <= s2_value;
        end
    end

    // stage 1: source and above products
    logic signed [DATA_W-1:0]   s1_above;
    logic signed [PROD_W-1:0]   p_src, p_abv;

    always_comb begin
        s1_above = r_s1_fwd ? r_s1_fwd_data : r_rd_data;
        p_src    = r_source_gain * r_s1.src;
        p_abv    = r_neighbour_gain * s1_above;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2.p_sa   <= PSA_W'(p_src) - PSA_W'(p_abv);
            r_s2.above  <= s1_above;
            r_s2.bnd    <= r_s1.bnd;
            r_s2.col    <= r_s1.col;
            r_s2.is_bnd <= r_s1.is_bnd;
            r_s2.rend   <= r_s1.rend;
            r_s2.gend   <= r_s1.gend;
        end
    end

    // left and diagonal follow each finished item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
        end else if (s2_go) begin
            r_left <= s2_value;
            r_diag <= r_s2.above;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s2_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out.value <= s2_value;
            r_out.rend  <= r_s2.rend;
            r_out.gend  <= r_s2.gend;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_solution_value = r_out.value;
    assign o_row_end        = r_out.rend;
    assign o_grid_end       = r_out.gend;

    // checks
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s2_valid))
        else $error("result item appeared without a loop stage item");

    a_bnd_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_go && r_s2.is_bnd) |=> (r_out.value == $past(r_s2.bnd)))
        else $error("boundary point did not take the boundary value");

    a_grid_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_grid_end) |-> o_row_end)
        else $error("grid end without row end");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted item lost before stage 1");

endmodule

// File: tb/advection_box_scheme_stencil_tb.sv
`timescale 1ns / 1ps

module advection_box_scheme_stencil_tb;
    import advbox_pkg::*;

    localparam int     RANDOM_ITEMS = 650;
    localparam int     FILL_ITEMS   = 64;
    localparam int     MAX_REPORTS  = 10;
    localparam int     DRAIN_CYCLES = 12;
    localparam longint TIMEOUT_NS   = 64'd12_000_000;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = CFG_IDX_W'(REG_NEIGHBOUR_GAIN + 1);
    localparam logic [CFG_IDX_W-1:0] LAST_REG_INDEX   = {CFG_IDX_W{1'b1}};
    localparam logic [DATA_W-1:0]    ONE_Q            = 1 << FRAC_BITS;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              row_end;
        logic              grid_end;
    } t_grid_point;

    // one directed step: a register write or a grid point
    typedef struct {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [DATA_W-1:0]    value_a;
        logic [DATA_W-1:0]    value_b;
        logic                 has_typed;
        t_grid_point          typed;
    } t_stim_row;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_ready;
    logic signed [DATA_W-1:0] i_source_value   = '0;
    logic signed [DATA_W-1:0] i_boundary_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready      = 1'b0;
    logic signed [DATA_W-1:0] o_solution_value;
    logic                     o_row_end;
    logic                     o_grid_end;
    logic                     i_cfg_valid      = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index      = '0;
    logic [DATA_W-1:0]        i_cfg_data       = '0;

    advection_box_scheme_stencil uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_source_value   (i_source_value),
        .i_boundary_value (i_boundary_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_solution_value (o_solution_value),
        .o_row_end        (o_row_end),
        .o_grid_end       (o_grid_end),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the stencil state and registers
    logic [ROW_LEN_W-1:0]     grid_row_length;
    logic [ROW_W-1:0]         grid_row_count;
    logic signed [DATA_W-1:0] grid_source_gain;
    logic signed [DATA_W-1:0] grid_neighbour_gain;
    logic signed [DATA_W-1:0] row_above [MAX_ROW_LENGTH];
    logic signed [DATA_W-1:0] left_point;
    logic signed [DATA_W-1:0] diag_point;
    int unsigned              next_col;
    int unsigned              next_row;

    t_grid_point expected_points [$];
    t_stim_row   directed_rows [$];
    logic        typed_pending = 1'b0;
    t_grid_point typed_point   = '0;
    logic        steady_input  = 1'b0;

    int items_sent     = 0;
    int results_seen   = 0;
    int reg_writes     = 0;
    int grids_seen     = 0;
    int error_count    = 0;

    // box scheme for one grid point, advances the raster position
    task automatic advance_grid_point(input logic signed [DATA_W-1:0] src,
                                      input logic signed [DATA_W-1:0] bnd,
                                      output t_grid_point point);
        int unsigned              len;
        int unsigned              rows;
        int unsigned              col;
        logic signed [DATA_W-1:0] above;
        logic signed [DATA_W-1:0] value;
        logic signed [67:0]       gain_w, ngain_w, src_w, left_w, above_w, diag_w;
        logic signed [67:0]       total;
        logic signed [67:0]       scaled;
        logic                     rend;
        logic                     gend;
        len = grid_row_length;
        if (len < 2) len = 2;
        if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
        rows = (grid_row_count == 0) ? 1 : grid_row_count;
        col = (next_col >= len) ? len - 1 : next_col;
        above = row_above[col];
        if (next_row == 0 || col == 0) begin
            value = bnd;
        end else begin
            gain_w  = grid_source_gain;
            ngain_w = grid_neighbour_gain;
            src_w   = src;
            left_w  = left_point;
            above_w = above;
            diag_w  = diag_point;
            // exact sum, floor shift, then diagonal and saturation
            total  = gain_w * src_w - ngain_w * (left_w + above_w);
            scaled = (total >>> FRAC_BITS) + diag_w;
            if (scaled > DATA_MAX) value = DATA_MAX;
            else if (scaled < DATA_MIN) value = DATA_MIN;
            else value = scaled[DATA_W-1:0];
        end
        row_above[col] = value;
        left_point     = value;
        diag_point     = above;
        rend = (col + 1 >= len);
        gend = rend && (next_row + 1 >= rows);
        if (rend) begin
            next_col = 0;
            next_row = gend ? 0 : ((next_row + 1) & 32'hFFFF);
        end else begin
            next_col = col + 1;
        end
        point = '{value, rend, gend};
    endtask

    // predict on accepted items, compare accepted results
    always @(posedge i_clk) begin : scoreboard
        t_grid_point got;
        t_grid_point want;
        if (!i_rst_n) begin
            grid_row_length     = ROW_LEN_W'(MAX_ROW_LENGTH);
            grid_row_count      = ROW_W'(2000);
            grid_source_gain    = DATA_W'(32768);
            grid_neighbour_gain = '0;
            for (int n = 0; n < MAX_ROW_LENGTH; n++) row_above[n] = '0;
            left_point = '0;
            diag_point = '0;
            next_col   = 0;
            next_row   = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    REG_ROW_LENGTH:     grid_row_length = i_cfg_data[ROW_LEN_W-1:0];
                    REG_ROW_COUNT:      grid_row_count = i_cfg_data[ROW_W-1:0];
                    REG_SOURCE_GAIN:    grid_source_gain = i_cfg_data;
                    REG_NEIGHBOUR_GAIN: grid_neighbour_gain = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                advance_grid_point(i_source_value, i_boundary_value, want);
                expected_points.push_back(typed_pending ? typed_point : want);
                items_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_solution_value, o_row_end, o_grid_end};
                results_seen++;
                if (expected_points.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: value %h row_end %b grid_end %b",
                                 $time, got.value, got.row_end, got.grid_end);
                end else begin
                    want = expected_points.pop_front();
                    if (want.grid_end) grids_seen++;
                    if (got.value !== want.value || got.row_end !== want.row_end ||
                        got.grid_end !== want.grid_end) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: result %0d expected %h/%b/%b got %h/%b/%b",
                                     $time, results_seen, want.value, want.row_end,
                                     want.grid_end, got.value, got.row_end, got.grid_end);
                    end
                end
            end
        end
    end

    // idle length, mostly short and now and then long
    function automatic int idle_cycles();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 2);
        if (pick < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // mostly moderate Q16.16 values, some full range, some extremes
    function automatic logic [DATA_W-1:0] sample_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return $urandom_range(0, 2**21) - 2**20;
        if (pick < 90) return $urandom;
        case ($urandom_range(0, 3))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] gain_value();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(0, 2**18) - 2**17;
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 4))
            0:       return DATA_MAX;
            1:       return DATA_MIN;
            2:       return '0;
            3:       return '1;
            default: return ONE_Q;
        endcase
    endfunction

    // short rows mostly, with clamped-low and longer rows now and then,
    // never past the columns that the first long row wrote
    function automatic logic [DATA_W-1:0] row_length_word();
        logic [DATA_W-1:0] word;
        int unsigned       pick;
        word = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 65) word[ROW_LEN_W-1:0] = ROW_LEN_W'($urandom_range(2, 8));
        else if (pick < 85) word[ROW_LEN_W-1:0] = ROW_LEN_W'($urandom_range(9, 40));
        else if (pick < 92) word[ROW_LEN_W-1:0] = ROW_LEN_W'($urandom_range(0, 1));
        else word[ROW_LEN_W-1:0] = ROW_LEN_W'($urandom_range(41, FILL_ITEMS));
        return word;
    endfunction

    function automatic logic [DATA_W-1:0] row_count_word();
        logic [DATA_W-1:0] word;
        int unsigned       pick;
        word = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60) word[ROW_W-1:0] = ROW_W'($urandom_range(1, 4));
        else if (pick < 80) word[ROW_W-1:0] = ROW_W'($urandom_range(5, 20));
        else if (pick < 88) word[ROW_W-1:0] = '0;
        else if (pick < 94) word[ROW_W-1:0] = '1;
        return word;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        directed_rows.push_back('{1'b1, idx, data, '0, 1'b0, '0});
    endfunction

    function automatic void add_point(input logic [DATA_W-1:0] src,
                                      input logic [DATA_W-1:0] bnd);
        directed_rows.push_back('{1'b0, '0, src, bnd, 1'b0, '0});
    endfunction

    function automatic void add_typed(input logic [DATA_W-1:0] src,
                                      input logic [DATA_W-1:0] bnd,
                                      input logic [DATA_W-1:0] value,
                                      input logic rend, input logic gend);
        directed_rows.push_back('{1'b0, '0, src, bnd, 1'b1, '{value, rend, gend}});
    endfunction

    // drive one item at the falling edge, hold until accepted
    task automatic send_item(input logic [DATA_W-1:0] src, input logic [DATA_W-1:0] bnd,
                             input logic has_typed, input t_grid_point typed);
        int gap;
        gap = steady_input ? 0 : idle_cycles();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_source_value   <= src;
        i_boundary_value <= bnd;
        typed_pending = has_typed;
        typed_point   = typed;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // new random settings for the next stretch of items
    task automatic random_settings();
        if ($urandom_range(0, 1)) write_register(REG_ROW_LENGTH, row_length_word());
        if ($urandom_range(0, 1)) write_register(REG_ROW_COUNT, row_count_word());
        if ($urandom_range(0, 1)) write_register(REG_SOURCE_GAIN, gain_value());
        if ($urandom_range(0, 1)) write_register(REG_NEIGHBOUR_GAIN, gain_value());
        if ($urandom_range(0, 19) == 0)
            write_register(CFG_IDX_W'($urandom_range(UNUSED_REG_INDEX, LAST_REG_INDEX)),
                           $urandom);
    endtask

    // result side: ready bursts with random stalls
    initial begin : result_ready_driver
        int gap;
        forever begin
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            repeat (($urandom_range(0, 99) < 20) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12))
                @(negedge i_clk);
            gap = idle_cycles();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("watchdog expired with %0d results outstanding", expected_points.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int random_items;
        int burst;
        random_items = 0;

        // directed part: reset values, clamping, extremes, rounding
        add_typed(DATA_MAX, DATA_MIN, DATA_MIN, 1'b0, 1'b0);
        add_typed(DATA_MIN, DATA_MAX, DATA_MAX, 1'b0, 1'b0);
        // length below two, column past the new end closes the row
        add_write(REG_ROW_LENGTH, 32'h0000_0000);
        add_typed(32'h0000_0000, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0);
        // row count zero acts as one, row past the count ends the grid
        add_write(REG_ROW_COUNT, 32'h0000_0000);
        add_typed(ONE_Q, 32'h0000_abcd, 32'h0000_abcd, 1'b0, 1'b0);
        add_point(32'h0002_0000, 32'h0000_0000);
        // full-scale gains, saturation both ways
        add_write(REG_ROW_LENGTH, 32'h0000_0003);
        add_write(REG_ROW_COUNT, 32'h0000_0003);
        add_write(REG_SOURCE_GAIN, DATA_MAX);
        add_write(REG_NEIGHBOUR_GAIN, DATA_MIN);
        add_typed(DATA_MAX, DATA_MAX, DATA_MAX, 1'b0, 1'b0);
        add_typed(DATA_MIN, DATA_MIN, DATA_MIN, 1'b0, 1'b0);
        add_typed(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0);
        add_typed(DATA_MAX, ONE_Q, ONE_Q, 1'b0, 1'b0);
        add_point(DATA_MAX, 32'h0000_0000);
        add_point(DATA_MIN, DATA_MAX);
        add_typed(32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
        add_point(DATA_MIN, 32'h0000_0000);
        add_point(DATA_MAX, 32'h0000_0000);
        add_write(REG_SOURCE_GAIN, DATA_MIN);
        add_write(REG_NEIGHBOUR_GAIN, DATA_MAX);
        add_typed(32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0);
        add_typed(32'h0000_0000, DATA_MIN, DATA_MIN, 1'b0, 1'b0);
        add_typed(32'h0000_0000, DATA_MAX, DATA_MAX, 1'b1, 1'b0);
        add_typed(DATA_MIN, DATA_MAX, DATA_MAX, 1'b0, 1'b0);
        add_point(DATA_MIN, 32'h0000_0000);
        add_point(DATA_MAX, 32'h0000_0000);
        // tiny negative gains exercise the floor on negative sums
        add_write(REG_SOURCE_GAIN, 32'hffff_ffff);
        add_write(REG_NEIGHBOUR_GAIN, 32'hffff_ffff);
        add_write(UNUSED_REG_INDEX, 32'h0000_0005);
        add_typed(32'h0000_0000, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0);
        add_point(32'h0000_0001, 32'h0000_0000);
        add_point(32'hffff_ffff, 32'h0000_0000);

        // reset
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_write)
                write_register(directed_rows[n].reg_index, directed_rows[n].value_a);
            else
                send_item(directed_rows[n].value_a, directed_rows[n].value_b,
                          directed_rows[n].has_typed, directed_rows[n].typed);
        end

        // long first row writes the line buffer ahead of the random rows,
        // length above max clamps
        write_register(REG_ROW_LENGTH, '1);
        write_register(REG_ROW_COUNT, 32'h0000_0002);
        write_register(REG_SOURCE_GAIN, gain_value());
        write_register(REG_NEIGHBOUR_GAIN, gain_value());
        repeat (FILL_ITEMS)
            send_item(sample_value(), sample_value(), 1'b0, '0);

        // random stretches, settings change between them mid-grid
        while (random_items < RANDOM_ITEMS) begin
            random_settings();
            steady_input = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(8, 60);
            repeat (burst) begin
                if ($urandom_range(0, 29) == 0) wait_drained();
                send_item(sample_value(), sample_value(), 1'b0, '0);
                random_items++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d grid points, %0d results and %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("%0d grids closed, row lengths from clamped-low to %0d points",
                 grids_seen, FILL_ITEMS);
        if (error_count == 0 && expected_points.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d failures", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/advbox_pkg.sv
rtl/advection_box_scheme_stencil.sv
tb/advection_box_scheme_stencil_tb.sv
